@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define LRFC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also checks during reset.
`define LRFC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/lrfc_pkg.sv @@
// Shared types and constants for the rectangle fill command stream unit.
// No dependencies; used by every module of the block.
`default_nettype none

package lrfc_pkg;

	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_RUN    = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

	localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
	localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;

	localparam logic [9:0] PANEL_WIDTH_RST  = 10'd240;
	localparam logic [9:0] PANEL_HEIGHT_RST = 10'd320;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic {
		FS_IDLE,
		FS_RUN
	} front_state_t;

	typedef enum logic {
		BS_IDLE,
		BS_RUN
	} back_state_t;

	// One clipped fill or none, optionally followed by the request's status word.
	typedef struct packed {
		logic        do_fill;
		logic        end_flag;
		logic        code;
		logic [9:0]  x0;
		logic [9:0]  x1;
		logic [9:0]  y0;
		logic [9:0]  y1;
		logic [9:0]  cw;
		logic [9:0]  ch;
		logic [15:0] color;
	} job_t;

endpackage

`default_nettype wire

@@ hw/rtl/lrfc_front.sv @@
// Front end: takes requests, holds the panel size registers, splits outlines
// into edges, checks and clips each fill and pushes jobs. Uses lrfc_pkg.
`default_nettype none

module lrfc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  wire                 opcode,
	input  wire  [9:0]          rect_x,
	input  wire  [9:0]          rect_y,
	input  wire  [9:0]          rect_width,
	input  wire  [9:0]          rect_height,
	input  wire  [15:0]         fill_color,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [9:0]          cfg_data,
	output lrfc_pkg::job_t      job,
	output logic                job_push,
	input  wire                 job_full
);

	lrfc_pkg::front_state_t state_q, state_d;
	logic [9:0]  pw_q, ph_q;
	logic        op_q;
	logic [9:0]  x_q, y_q, w_q, h_q;
	logic [15:0] color_q;
	logic [1:0]  edge_q;

	logic        accept;
	logic [10:0] ex, ey;
	logic [9:0]  ew, eh;
	logic [11:0] xsum, ysum, xlast, ylast;
	logic        too_thin, reject;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q <= lrfc_pkg::PANEL_WIDTH_RST;
			ph_q <= lrfc_pkg::PANEL_HEIGHT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == lrfc_pkg::REG_PANEL_WIDTH) begin
				pw_q <= cfg_data;
			end else if (cfg_index == lrfc_pkg::REG_PANEL_HEIGHT) begin
				ph_q <= cfg_data;
			end
		end
	end

	// Edge geometry: outline edges are top, bottom, left, right; a plain
	// fill uses the top slot with the full height.
	always_comb begin
		ex = {1'b0, x_q};
		ey = {1'b0, y_q};
		ew = w_q;
		eh = h_q;
		case (edge_q)
			2'd0: begin
				eh = op_q ? 10'd1 : h_q;
			end
			2'd1: begin
				ey = {1'b0, y_q} + {1'b0, h_q} - 11'd1;
				eh = 10'd1;
			end
			2'd2: begin
				ew = 10'd1;
			end
			default: begin
				ex = {1'b0, x_q} + {1'b0, w_q} - 11'd1;
				ew = 10'd1;
			end
		endcase
	end

	always_comb begin
		too_thin = op_q && ((w_q < 10'd2) || (h_q < 10'd2));
		reject   = (ew == 10'd0) || (eh == 10'd0) ||
			(ex >= {1'b0, pw_q}) || (ey >= {1'b0, ph_q});
		xsum  = {1'b0, ex} + {2'b00, ew};
		ysum  = {1'b0, ey} + {2'b00, eh};
		xlast = xsum - 12'd1;
		ylast = ysum - 12'd1;

		job.do_fill  = !too_thin && !reject;
		job.end_flag = !op_q || too_thin || reject || (edge_q == 2'd3);
		job.code     = (too_thin || reject) ? lrfc_pkg::STATUS_REJECTED
			: lrfc_pkg::STATUS_OK;
		job.x0       = ex[9:0];
		job.y0       = ey[9:0];
		job.color    = color_q;
		if (xsum > {2'b00, pw_q}) begin
			job.cw = pw_q - ex[9:0];
			job.x1 = pw_q - 10'd1;
		end else begin
			job.cw = ew;
			job.x1 = xlast[9:0];
		end
		if (ysum > {2'b00, ph_q}) begin
			job.ch = ph_q - ey[9:0];
			job.y1 = ph_q - 10'd1;
		end else begin
			job.ch = eh;
			job.y1 = ylast[9:0];
		end
	end

	always_comb begin
		job_push = (state_q == lrfc_pkg::FS_RUN) && !job_full;
		full     = (state_q == lrfc_pkg::FS_RUN) && !(job_push && job.end_flag);
		accept   = push && !full;
		state_d  = state_q;
		unique case (state_q)
			lrfc_pkg::FS_IDLE: begin
				if (accept) begin
					state_d = lrfc_pkg::FS_RUN;
				end
			end
			lrfc_pkg::FS_RUN: begin
				if (job_push && job.end_flag && !accept) begin
					state_d = lrfc_pkg::FS_IDLE;
				end
			end
			default: begin
				state_d = lrfc_pkg::FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrfc_pkg::FS_IDLE;
			edge_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				edge_q <= 2'd0;
			end else if (job_push) begin
				edge_q <= edge_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			x_q     <= rect_x;
			y_q     <= rect_y;
			w_q     <= rect_width;
			h_q     <= rect_height;
			color_q <= fill_color;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lrfc_queue.sv @@
// Short job queue between front and back end.
// Depends on lrfc_pkg for the job word and depth.
`default_nettype none

module lrfc_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  lrfc_pkg::job_t      wr_job,
	output logic                full,
	input  wire                 rd_en,
	output lrfc_pkg::job_t      rd_job,
	output logic                empty
);

	lrfc_pkg::job_t mem [lrfc_pkg::QDEPTH];
	logic [lrfc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lrfc_pkg::QPTR_W:0]   count_q;
	logic do_wr, do_rd;

	assign full   = (count_q == (lrfc_pkg::QPTR_W+1)'(lrfc_pkg::QDEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lrfc_back.sv @@
// Back end: turns each job into its panel command words, its status word or
// both, one a cycle unless stalled, via an output register. Uses lrfc_pkg.
`default_nettype none

module lrfc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lrfc_pkg::job_t      job,
	input  wire                 job_empty,
	output logic                job_pop,
	output logic                empty,
	input  wire                 pop,
	output logic [1:0]          item_kind,
	output logic [15:0]         item_value,
	output logic [19:0]         run_length,
	output logic                status_code,
	output logic                last_item
);

	localparam logic [3:0] STEP_COL    = 4'd0;
	localparam logic [3:0] STEP_X0_HI  = 4'd1;
	localparam logic [3:0] STEP_X0_LO  = 4'd2;
	localparam logic [3:0] STEP_X1_HI  = 4'd3;
	localparam logic [3:0] STEP_X1_LO  = 4'd4;
	localparam logic [3:0] STEP_PAGE   = 4'd5;
	localparam logic [3:0] STEP_Y0_HI  = 4'd6;
	localparam logic [3:0] STEP_Y0_LO  = 4'd7;
	localparam logic [3:0] STEP_Y1_HI  = 4'd8;
	localparam logic [3:0] STEP_Y1_LO  = 4'd9;
	localparam logic [3:0] STEP_MEMWR  = 4'd10;
	localparam logic [3:0] STEP_RUN    = 4'd11;
	localparam logic [3:0] STEP_STATUS = 4'd12;

	lrfc_pkg::back_state_t state_q, state_d;
	lrfc_pkg::job_t cur_q;
	logic [3:0]  step_q;
	logic [19:0] run_q;
	logic        out_valid_q;

	logic        adv, emit, last_step, done, load;
	logic [1:0]  kind_d;
	logic [15:0] value_d;

	assign empty     = !out_valid_q;
	assign adv       = !out_valid_q || pop;
	assign emit      = (state_q == lrfc_pkg::BS_RUN) && adv;
	assign last_step = (step_q == STEP_STATUS) || ((step_q == STEP_RUN) && !cur_q.end_flag);
	assign done      = emit && last_step;
	assign load      = !job_empty && ((state_q == lrfc_pkg::BS_IDLE) || done);
	assign job_pop   = load;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrfc_pkg::BS_IDLE: begin
				if (load) begin
					state_d = lrfc_pkg::BS_RUN;
				end
			end
			lrfc_pkg::BS_RUN: begin
				if (done && !load) begin
					state_d = lrfc_pkg::BS_IDLE;
				end
			end
			default: begin
				state_d = lrfc_pkg::BS_IDLE;
			end
		endcase
	end

	always_comb begin
		kind_d  = lrfc_pkg::KIND_DATA;
		value_d = '0;
		unique case (step_q)
			STEP_COL: begin
				kind_d  = lrfc_pkg::KIND_CMD;
				value_d = {8'd0, lrfc_pkg::CMD_COLUMN_SET};
			end
			STEP_X0_HI:  value_d = {14'd0, cur_q.x0[9:8]};
			STEP_X0_LO:  value_d = {8'd0, cur_q.x0[7:0]};
			STEP_X1_HI:  value_d = {14'd0, cur_q.x1[9:8]};
			STEP_X1_LO:  value_d = {8'd0, cur_q.x1[7:0]};
			STEP_PAGE: begin
				kind_d  = lrfc_pkg::KIND_CMD;
				value_d = {8'd0, lrfc_pkg::CMD_PAGE_SET};
			end
			STEP_Y0_HI:  value_d = {14'd0, cur_q.y0[9:8]};
			STEP_Y0_LO:  value_d = {8'd0, cur_q.y0[7:0]};
			STEP_Y1_HI:  value_d = {14'd0, cur_q.y1[9:8]};
			STEP_Y1_LO:  value_d = {8'd0, cur_q.y1[7:0]};
			STEP_MEMWR: begin
				kind_d  = lrfc_pkg::KIND_CMD;
				value_d = {8'd0, lrfc_pkg::CMD_MEMORY_WRITE};
			end
			STEP_RUN: begin
				kind_d  = lrfc_pkg::KIND_RUN;
				value_d = cur_q.color;
			end
			default: begin
				kind_d  = lrfc_pkg::KIND_STATUS;
				value_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrfc_pkg::BS_IDLE;
			step_q      <= STEP_COL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= job.do_fill ? STEP_COL : STEP_STATUS;
			end else if (emit && !last_step) begin
				step_q <= step_q + 4'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pixel count is taken at load; it is first needed eleven words later.
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= job;
			run_q <= 20'(job.cw * job.ch);
		end
		if (emit) begin
			item_kind   <= kind_d;
			item_value  <= value_d;
			run_length  <= (step_q == STEP_RUN) ? run_q : 20'd0;
			status_code <= (step_q == STEP_STATUS) ? cur_q.code : 1'b0;
			last_item   <= (step_q == STEP_STATUS);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lcd_rect_fill_command_stream_unit.sv @@
// Top level of the rectangle fill command stream unit.
// Depends on lrfc_pkg, lrfc_front, lrfc_queue and lrfc_back.
`default_nettype none

// Takes fill or outline rectangle requests and emits the panel command
// stream, one word a cycle unless the output stalls. An accepted fill
// gives 13 words (column set, page set, memory write, pixel run, status);
// a rejected fill gives only its status word; an outline gives up to four
// fills and a status word, 49 words at most. Output rate is set by the
// back end, which emits one word per cycle from its output register while
// not stalled; the front end splits requests into jobs, and a four-entry
// job queue lets it take the next request while the back end is still
// emitting. Panel size registers reset to 240 x 320 and should be written
// only while no request is in flight. No clearing pass follows reset.
module lcd_rect_fill_command_stream_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire         opcode,
	input  wire  [9:0]  rect_x,
	input  wire  [9:0]  rect_y,
	input  wire  [9:0]  rect_width,
	input  wire  [9:0]  rect_height,
	input  wire  [15:0] fill_color,
	output logic        empty,
	input  wire         pop,
	output logic [1:0]  item_kind,
	output logic [15:0] item_value,
	output logic [19:0] run_length,
	output logic        status_code,
	output logic        last_item,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [9:0]  cfg_data
);

	lrfc_pkg::job_t wr_job, rd_job;
	logic job_push, job_full, job_pop, job_empty;

	lrfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.fill_color  (fill_color),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.job         (wr_job),
		.job_push    (job_push),
		.job_full    (job_full)
	);

	lrfc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (wr_job),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_job (rd_job),
		.empty  (job_empty)
	);

	lrfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (rd_job),
		.job_empty   (job_empty),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.item_kind   (item_kind),
		.item_value  (item_value),
		.run_length  (run_length),
		.status_code (status_code),
		.last_item   (last_item)
	);

endmodule

`default_nettype wire

@@ hw/rtl/lrfc_checker.sv @@
// Port-level checker for the rectangle fill command stream unit, bound to
// the top level. Depends on lrfc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lrfc_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        empty,
	input  wire        pop,
	input  wire [1:0]  item_kind,
	input  wire [19:0] run_length,
	input  wire        status_code,
	input  wire        last_item
);

	`LRFC_ASSERT(a_last_is_status, clk, arst_n, (!empty && last_item) |-> (item_kind == lrfc_pkg::KIND_STATUS), "last word is not a status word")
	`LRFC_ASSERT(a_status_is_last, clk, arst_n, (!empty && (item_kind == lrfc_pkg::KIND_STATUS)) |-> last_item, "status word not marked last")
	`LRFC_ASSERT(a_run_only, clk, arst_n, (!empty && (item_kind != lrfc_pkg::KIND_RUN)) |-> (run_length == 20'd0), "pixel count on a non-run word")
	`LRFC_ASSERT(a_code_only, clk, arst_n, (!empty && (item_kind != lrfc_pkg::KIND_STATUS)) |-> (status_code == 1'b0), "status code on a non-status word")
	`LRFC_ASSERT(a_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(item_kind) && $stable(run_length)), "waiting word changed")

endmodule

bind lcd_rect_fill_command_stream_unit lrfc_checker u_lrfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.item_kind   (item_kind),
	.run_length  (run_length),
	.status_code (status_code),
	.last_item   (last_item)
);

`default_nettype wire

@@ dv/lrfc_tb_pkg.sv @@
`timescale 1ns / 100ps
// Request and word types plus the expected-stream checker for the rect fill unit bench.
// Depends on lrfc_pkg for word kinds, panel commands, register indexes and status codes.

package lrfc_tb_pkg;

	import lrfc_pkg::*;

	localparam logic OP_FILL    = 1'b0;
	localparam logic OP_OUTLINE = 1'b1;

	// indexes with no register behind them
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic        op;
		logic [9:0]  x;
		logic [9:0]  y;
		logic [9:0]  w;
		logic [9:0]  h;
		logic [15:0] color;
	} rect_req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic [19:0] run;
		logic        code;
		logic        last;
	} panel_word_t;

	class stream_checker;

		int unsigned panel_w;
		int unsigned panel_h;
		panel_word_t due_words[$];
		int          errors;
		int          word_no;

		function new();
			panel_w = PANEL_WIDTH_RST;
			panel_h = PANEL_HEIGHT_RST;
			errors  = 0;
			word_no = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [9:0] val);
			if (idx == REG_PANEL_WIDTH)
				panel_w = val;
			else if (idx == REG_PANEL_HEIGHT)
				panel_h = val;
		endfunction

		function int pending_count();
			return due_words.size();
		endfunction

		function void add_word(logic [1:0] kind, logic [15:0] value, logic [19:0] run,
				logic code, logic last);
			panel_word_t wd;
			wd = '{kind, value, run, code, last};
			due_words.push_back(wd);
		endfunction

		function void add_coords(int unsigned lo, int unsigned hi);
			add_word(KIND_DATA, 16'((lo >> 8) & 8'hFF), '0, STATUS_OK, 1'b0);
			add_word(KIND_DATA, 16'(lo & 8'hFF), '0, STATUS_OK, 1'b0);
			add_word(KIND_DATA, 16'((hi >> 8) & 8'hFF), '0, STATUS_OK, 1'b0);
			add_word(KIND_DATA, 16'(hi & 8'hFF), '0, STATUS_OK, 1'b0);
		endfunction

		// One clipped fill; nothing is queued when it is rejected.
		function bit expand_fill(int unsigned x, int unsigned y, int unsigned w,
				int unsigned h, logic [15:0] color);
			int unsigned cw;
			int unsigned ch;
			if (w == 0 || h == 0)
				return 1'b0;
			if (x >= panel_w || y >= panel_h)
				return 1'b0;
			cw = (x + w > panel_w) ? panel_w - x : w;
			ch = (y + h > panel_h) ? panel_h - y : h;
			add_word(KIND_CMD, 16'(CMD_COLUMN_SET), '0, STATUS_OK, 1'b0);
			add_coords(x, x + cw - 1);
			add_word(KIND_CMD, 16'(CMD_PAGE_SET), '0, STATUS_OK, 1'b0);
			add_coords(y, y + ch - 1);
			add_word(KIND_CMD, 16'(CMD_MEMORY_WRITE), '0, STATUS_OK, 1'b0);
			add_word(KIND_RUN, color, 20'(cw * ch), STATUS_OK, 1'b0);
			return 1'b1;
		endfunction

		function void note_request(rect_req_t r);
			int unsigned x;
			int unsigned y;
			int unsigned w;
			int unsigned h;
			bit ok;
			x = r.x;
			y = r.y;
			w = r.w;
			h = r.h;
			if (r.op == OP_FILL) begin
				ok = expand_fill(x, y, w, h, r.color);
			end else if (w < 2 || h < 2) begin
				ok = 1'b0;
			end else begin
				// edges in order top, bottom, left, right; stop at the first reject
				ok = expand_fill(x, y, w, 1, r.color);
				if (ok)
					ok = expand_fill(x, y + h - 1, w, 1, r.color);
				if (ok)
					ok = expand_fill(x, y, 1, h, r.color);
				if (ok)
					ok = expand_fill(x + w - 1, y, 1, h, r.color);
			end
			add_word(KIND_STATUS, '0, '0, ok ? STATUS_OK : STATUS_REJECTED, 1'b1);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("mismatch: %s", msg);
		endtask

		task check_word(panel_word_t got);
			panel_word_t exp;
			if (due_words.size() == 0) begin
				report($sformatf("word %0d arrived with nothing due (kind %0d value %h)",
					word_no, got.kind, got.value));
			end else begin
				exp = due_words.pop_front();
				if (got.kind !== exp.kind)
					report($sformatf("word %0d kind %0d, want %0d", word_no, got.kind, exp.kind));
				if (got.value !== exp.value)
					report($sformatf("word %0d value %h, want %h", word_no, got.value, exp.value));
				if (got.run !== exp.run)
					report($sformatf("word %0d run %0d, want %0d", word_no, got.run, exp.run));
				if (got.code !== exp.code)
					report($sformatf("word %0d status %b, want %b", word_no, got.code, exp.code));
				if (got.last !== exp.last)
					report($sformatf("word %0d last %b, want %b", word_no, got.last, exp.last));
			end
			word_no++;
		endtask

	endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Bench top for lcd_rect_fill_command_stream_unit: directed and random requests under
// bursty input and stalling output. Depends on lrfc_pkg and lrfc_tb_pkg.

module tb_top;

	import lrfc_pkg::*;
	import lrfc_tb_pkg::*;

	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 6;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic        opcode      = 1'b0;
	logic [9:0]  rect_x      = '0;
	logic [9:0]  rect_y      = '0;
	logic [9:0]  rect_width  = '0;
	logic [9:0]  rect_height = '0;
	logic [15:0] fill_color  = '0;
	logic        pop         = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic [1:0]  cfg_index   = '0;
	logic [9:0]  cfg_data    = '0;
	logic        full;
	logic        empty;
	logic        cfg_ready;
	logic [1:0]  item_kind;
	logic [15:0] item_value;
	logic [19:0] run_length;
	logic        status_code;
	logic        last_item;

	int hold_req = 0;

	stream_checker sb = new();

	lcd_rect_fill_command_stream_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.fill_color (fill_color),
		.empty      (empty),
		.pop        (pop),
		.item_kind  (item_kind),
		.item_value (item_value),
		.run_length (run_length),
		.status_code(status_code),
		.last_item  (last_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Leaves push high; the caller lowers it when a gap follows.
	task automatic send_req(input rect_req_t r);
		push        <= 1'b1;
		opcode      <= r.op;
		rect_x      <= r.x;
		rect_y      <= r.y;
		rect_width  <= r.w;
		rect_height <= r.h;
		fill_color  <= r.color;
		do @(posedge clk); while (full);
		sb.note_request(r);
	endtask

	task automatic send_rect(input logic op, input int x, input int y, input int w,
			input int h, input logic [15:0] color);
		send_req('{op, 10'(x), 10'(y), 10'(w), 10'(h), color});
	endtask

	task automatic drain();
		if (push)
			push <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic retune(input int unsigned w, input int unsigned h);
		drain();
		write_reg(REG_PANEL_WIDTH, 10'(w));
		write_reg(REG_PANEL_HEIGHT, 10'(h));
	endtask

	function automatic logic [9:0] pick_origin(int unsigned lim);
		case ($urandom_range(0, 9))
			0, 1: return 10'($urandom_range(0, 1023));
			2: return (lim == 0) ? 10'd0 : 10'(lim - 1 + $urandom_range(0, 1));
			default: return (lim == 0) ? 10'($urandom_range(0, 3))
					: 10'($urandom_range(0, lim - 1));
		endcase
	endfunction

	function automatic logic [9:0] pick_size(int unsigned room);
		case ($urandom_range(0, 9))
			0: return 10'($urandom_range(0, 2));
			1, 2: return 10'($urandom_range(0, 1023));
			3: return 10'($urandom_range(1, (room == 0) ? 1 : room + 1));
			default: return 10'($urandom_range(2, 40));
		endcase
	endfunction

	function automatic rect_req_t rand_rect();
		rect_req_t r;
		r.op    = 1'($urandom_range(0, 1));
		r.x     = pick_origin(sb.panel_w);
		r.y     = pick_origin(sb.panel_h);
		r.w     = pick_size((sb.panel_w > r.x) ? sb.panel_w - r.x : 0);
		r.h     = pick_size((sb.panel_h > r.y) ? sb.panel_h - r.y : 0);
		r.color = 16'($urandom_range(0, 65535));
		return r;
	endfunction

	// Output side: check each word taken, then choose pop for the next edge.
	initial begin
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned pop_odds;
		int          seen_hold;
		panel_word_t got;
		hold_left = 0;
		mode_left = 0;
		pop_odds  = 8;
		seen_hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = '{item_kind, item_value, run_length, status_code, last_item};
				sb.check_word(got);
			end
			if (seen_hold != hold_req) begin
				seen_hold = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				case ($urandom_range(0, 3))
					0: pop_odds = 8;
					1: pop_odds = 6;
					2: pop_odds = 4;
					default: pop_odds = 1;
				endcase
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(1, 8) <= pop_odds);
			end
		end
	end

	initial begin
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset panel 240 x 320
		send_rect(OP_FILL, 0, 0, 1, 1, 16'h0000);
		send_rect(OP_FILL, 1023, 1023, 1023, 1023, 16'hFFFF);
		send_rect(OP_FILL, 0, 0, 1023, 1023, 16'hAAAA);
		send_rect(OP_FILL, 5, 5, 0, 7, 16'h5555);
		send_rect(OP_FILL, 5, 5, 7, 0, 16'h1234);
		send_rect(OP_FILL, 239, 319, 5, 5, 16'hF800);
		send_rect(OP_FILL, 240, 0, 4, 4, 16'h07E0);
		send_rect(OP_FILL, 0, 320, 4, 4, 16'h001F);
		send_rect(OP_OUTLINE, 10, 10, 1, 30, 16'h1111);
		send_rect(OP_OUTLINE, 10, 10, 30, 1, 16'h2222);
		send_rect(OP_OUTLINE, 10, 10, 20, 30, 16'h3333);
		send_rect(OP_OUTLINE, 100, 300, 50, 40, 16'h4444);  // bottom edge off panel
		send_rect(OP_OUTLINE, 230, 10, 20, 20, 16'h6666);   // right edge off panel
		send_rect(OP_OUTLINE, 0, 0, 2, 2, 16'h7777);

		// writes to unused indexes must leave the panel alone
		drain();
		write_reg(REG_SPARE_LO, 10'd5);
		write_reg(REG_SPARE_HI, 10'd7);
		send_rect(OP_FILL, 200, 0, 100, 1, 16'h8888);

		retune(1023, 1023);
		send_rect(OP_FILL, 0, 0, 1023, 1023, 16'hFFFF);
		send_rect(OP_OUTLINE, 0, 0, 1023, 1023, 16'h0F0F);
		send_rect(OP_FILL, 1022, 1022, 1023, 1023, 16'hF0F0);

		retune(1, 1);
		send_rect(OP_FILL, 0, 0, 1, 1, 16'h9999);
		send_rect(OP_OUTLINE, 0, 0, 2, 2, 16'hBBBB);

		retune(0, 320);
		send_rect(OP_FILL, 0, 0, 1, 1, 16'hCCCC);
		send_rect(OP_OUTLINE, 0, 0, 5, 5, 16'hDDDD);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: retune(PANEL_WIDTH_RST, PANEL_HEIGHT_RST);
				1: retune($urandom_range(1, 1023), $urandom_range(1, 1023));
				2: retune(1023, 1023);
				3: retune($urandom_range(1, 16), $urandom_range(1, 16));
				4: retune(1, $urandom_range(1, 1023));
				5: retune($urandom_range(1, 1023), 0);
				default: retune($urandom_range(1, 1023), $urandom_range(1, 1023));
			endcase
			if (phase == 0) begin
				// output held off while requests keep coming, so the unit backs up
				hold_req <= hold_req + 1;
				repeat (24) send_req(rand_rect());
			end
			for (int i = (phase == 0) ? 24 : 0; i < PHASE_ITEMS; i++) begin
				send_req(rand_rect());
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 10);
					gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 3);
					if (gap != 0) begin
						push <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end else begin
					burst_left--;
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ lcd_rect_fill_command_stream_unit.f @@
+incdir+hw/rtl
hw/rtl/lrfc_pkg.sv
hw/rtl/lrfc_front.sv
hw/rtl/lrfc_queue.sv
hw/rtl/lrfc_back.sv
hw/rtl/lcd_rect_fill_command_stream_unit.sv
hw/rtl/lrfc_checker.sv
dv/lrfc_tb_pkg.sv
dv/tb_top.sv
